// ===== rtl/btc_pkg.sv =====
// Shared types, codes and helper functions of the bin threshold checker.
`default_nettype none

package btc_pkg;

    // Fixed field widths
    localparam int unsigned BIN_INDEX_W = 10;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned LIMIT_W     = 64;
    localparam int unsigned CNT_W       = 11;
    localparam int unsigned SUM_W       = CNT_W + 2;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned PLIM_W      = 12;

    // Item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_TYPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ENTRIES   = 3'd4;

    // Compare modes (signed)
    localparam logic signed [2:0] CMP_NEVER = 3'sd0;
    localparam logic signed [2:0] CMP_GE    = 3'sd1;
    localparam logic signed [2:0] CMP_LE    = -3'sd1;

    // Publish types
    localparam logic [1:0] PUB_ERRORS = 2'd0;
    localparam logic [1:0] PUB_WARN   = 2'd1;
    localparam logic [1:0] PUB_ALL    = 2'd2;

    // Bin classes
    localparam logic [1:0] CLS_GOOD = 2'd0;
    localparam logic [1:0] CLS_WARN = 2'd1;
    localparam logic [1:0] CLS_ERR  = 2'd2;
    localparam logic [1:0] CLS_SKIP = 2'd3;

    // Status codes
    localparam logic [1:0] ST_GREEN  = 2'd0;
    localparam logic [1:0] ST_YELLOW = 2'd1;
    localparam logic [1:0] ST_RED    = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One limit table entry
    typedef struct packed {
        logic signed [VALUE_W-1:0] warn_limit;
        logic signed [VALUE_W-1:0] error_limit;
        logic                      masked;
    } btc_entry_t;

    // Flag test of a content against a limit under a compare mode
    function automatic logic btc_flag(
        input logic signed [2:0]         mode,
        input logic signed [LIMIT_W-1:0] con,
        input logic signed [LIMIT_W-1:0] lim
    );
        logic hit;
        priority if (mode == CMP_GE)
            hit = (con >= lim);
        else if (mode > CMP_GE)
            hit = (con > lim);
        else if (mode == CMP_LE)
            hit = (con <= lim);
        else if (mode < CMP_LE)
            hit = (con < lim);
        else
            hit = 1'b0;
        return hit;
    endfunction

    // Saturating increment of a bin counter
    function automatic logic [CNT_W-1:0] btc_bump(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        if (c == CNT_MAX)
            n = CNT_MAX;
        else
            n = c + CNT_W'(1);
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bin_threshold_checker_top.sv =====
// Top level of the bin threshold checker: limit table, check pipeline, counters.
`default_nettype none

// Bin threshold checker. Load words (opcode 0) write one entry of the limit
// table (warning limit, error limit, mask bit) and give no result; check words
// (opcode 1) give one result word each. One word is accepted per clock cycle
// while in_stall is low. For a check word the limit table is read at the
// accepting edge, the scaled limits are registered in stage 2, and compare and
// counter update go into the output register. After reset the block sweeps
// all BINS entries of the limit table, one entry per cycle, setting every bin
// to masked; in_stall stays high during that sweep while configuration writes
// are still taken. Configuration should be written only when no check is in
// flight.
module bin_threshold_checker_top
    import btc_pkg::*;
#(
    parameter int unsigned BINS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    // Input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          opcode,
    input  wire logic [BIN_INDEX_W-1:0]        bin_index,
    input  wire logic signed [VALUE_W-1:0]     warn_limit,
    input  wire logic signed [VALUE_W-1:0]     error_limit,
    input  wire logic                          masked,
    input  wire logic signed [VALUE_W-1:0]     content,
    input  wire logic [VALUE_W-1:0]            bin_entries,
    input  wire logic [VALUE_W-1:0]            total_entries,
    input  wire logic                          first,
    input  wire logic                          last,
    // Output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         bin_class,
    output logic                               publish,
    output logic [CNT_W-1:0]                   error_count,
    output logic [CNT_W-1:0]                   warning_count,
    output logic [1:0]                         status,
    output logic                               done_res
);

    localparam int unsigned AW    = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int unsigned EXT_W = ((AW > BIN_INDEX_W) ? AW : BIN_INDEX_W) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [2:0]        compare_mode_reg;
    logic                     fraction_mode_reg;
    logic signed [PLIM_W-1:0] publish_limit_reg;
    logic [1:0]               publish_type_reg;
    logic [VALUE_W-1:0]       min_entries_reg;

    // Take configuration writes; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_mode_reg  <= CMP_GE;
            fraction_mode_reg <= 1'b0;
            publish_limit_reg <= '1;
            publish_type_reg  <= PUB_ERRORS;
            min_entries_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COMPARE_MODE:  compare_mode_reg  <= cfg_data[2:0];
                REG_FRACTION_MODE: fraction_mode_reg <= cfg_data[0];
                REG_PUBLISH_LIMIT: publish_limit_reg <= cfg_data[PLIM_W-1:0];
                REG_PUBLISH_TYPE:  publish_type_reg  <= cfg_data[1:0];
                REG_MIN_ENTRIES:   min_entries_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic clearing_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_accept;
    logic s2_move;
    logic s1_move;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = clearing_reg || !s1_ready;
    assign in_accept = in_valid && !in_stall;
    assign s2_move   = s2_valid_reg && out_ready;
    assign s1_move   = s1_valid_reg && s2_ready;

    // ------------------------------------------------------------------
    // Limit table and clearing sweep
    // ------------------------------------------------------------------
    logic [AW-1:0]    clr_addr_reg;
    logic [EXT_W-1:0] idx_ext;
    logic             idx_in_range;
    logic [AW-1:0]    idx_addr;
    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    btc_entry_t       tbl_wdata;
    btc_entry_t       load_entry;
    btc_entry_t       clear_entry;
    logic             tbl_re;
    btc_entry_t       tbl_rdata;

    assign idx_ext      = EXT_W'(bin_index);
    assign idx_in_range = (idx_ext < EXT_W'(BINS));
    assign idx_addr     = idx_ext[AW-1:0];

    assign load_entry.warn_limit  = warn_limit;
    assign load_entry.error_limit = error_limit;
    assign load_entry.masked      = masked;

    assign clear_entry.warn_limit  = '0;
    assign clear_entry.error_limit = '0;
    assign clear_entry.masked      = 1'b1;

    // Select sweep or load write
    always_comb
    begin
        if (clearing_reg)
        begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_addr_reg;
            tbl_wdata = clear_entry;
        end
        else
        begin
            tbl_we    = in_accept && (opcode == OP_LOAD) && idx_in_range;
            tbl_waddr = idx_addr;
            tbl_wdata = load_entry;
        end
    end

    assign tbl_re = in_accept && (opcode == OP_CHECK);

    // Advance the clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(BINS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    btc_ram #(
        .WIDTH ($bits(btc_entry_t)),
        .DEPTH (BINS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (idx_addr),
        .rdata (tbl_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: check word registered, table entry read
    // ------------------------------------------------------------------
    logic                      s1_in_range_reg;
    logic                      s1_few_reg;
    logic signed [VALUE_W-1:0] s1_content_reg;
    logic [VALUE_W-1:0]        s1_total_reg;
    logic                      s1_first_reg;
    logic                      s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= tbl_re;
        end
    end

    // Hold stage 1 payload until it moves on
    always_ff @(posedge clk)
    begin
        if (tbl_re)
        begin
            s1_in_range_reg <= idx_in_range;
            s1_few_reg      <= (bin_entries < min_entries_reg);
            s1_content_reg  <= content;
            s1_total_reg    <= total_entries;
            s1_first_reg    <= first;
            s1_last_reg     <= last;
        end
    end

    // Scale limits by the total entry count in fraction mode
    logic signed [LIMIT_W:0]   warn_prod;
    logic signed [LIMIT_W:0]   err_prod;
    logic signed [LIMIT_W-1:0] warn_lim;
    logic signed [LIMIT_W-1:0] err_lim;
    logic                      s1_skip;

    assign warn_prod = tbl_rdata.warn_limit * $signed({1'b0, s1_total_reg});
    assign err_prod  = tbl_rdata.error_limit * $signed({1'b0, s1_total_reg});

    always_comb
    begin
        if (fraction_mode_reg)
        begin
            warn_lim = warn_prod[LIMIT_W-1:0];
            err_lim  = err_prod[LIMIT_W-1:0];
        end
        else
        begin
            warn_lim = {{(LIMIT_W - VALUE_W){tbl_rdata.warn_limit[VALUE_W-1]}},
                        tbl_rdata.warn_limit};
            err_lim  = {{(LIMIT_W - VALUE_W){tbl_rdata.error_limit[VALUE_W-1]}},
                        tbl_rdata.error_limit};
        end
    end

    assign s1_skip = !s1_in_range_reg || tbl_rdata.masked || s1_few_reg;

    // ------------------------------------------------------------------
    // Stage 2: scaled limits registered
    // ------------------------------------------------------------------
    logic signed [LIMIT_W-1:0] s2_warn_lim_reg;
    logic signed [LIMIT_W-1:0] s2_err_lim_reg;
    logic signed [VALUE_W-1:0] s2_content_reg;
    logic                      s2_skip_reg;
    logic                      s2_first_reg;
    logic                      s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_warn_lim_reg <= warn_lim;
            s2_err_lim_reg  <= err_lim;
            s2_content_reg  <= s1_content_reg;
            s2_skip_reg     <= s1_skip;
            s2_first_reg    <= s1_first_reg;
            s2_last_reg     <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Classify, update counters, decide publish and status
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] err_cnt_reg;
    logic [CNT_W-1:0] warn_cnt_reg;
    logic [CNT_W-1:0] good_cnt_reg;
    logic [CNT_W-1:0] err_cnt_next;
    logic [CNT_W-1:0] warn_cnt_next;
    logic [CNT_W-1:0] good_cnt_next;
    logic [CNT_W-1:0] err_base;
    logic [CNT_W-1:0] warn_base;
    logic [CNT_W-1:0] good_base;
    logic signed [LIMIT_W-1:0] con_ext;
    logic [1:0]       cls;
    logic [SUM_W-1:0] cnt_sum;
    logic signed [SUM_W:0] lim_ext;
    logic             under_limit;
    logic             pub;
    logic [1:0]       st;

    assign con_ext = {{(LIMIT_W - VALUE_W){s2_content_reg[VALUE_W-1]}}, s2_content_reg};

    always_comb
    begin
        // Clear counters on the first bin of a histogram
        err_base  = s2_first_reg ? '0 : err_cnt_reg;
        warn_base = s2_first_reg ? '0 : warn_cnt_reg;
        good_base = s2_first_reg ? '0 : good_cnt_reg;

        err_cnt_next  = err_base;
        warn_cnt_next = warn_base;
        good_cnt_next = good_base;

        priority if (s2_skip_reg)
        begin
            cls = CLS_SKIP;
        end
        else if (btc_flag(compare_mode_reg, con_ext, s2_err_lim_reg))
        begin
            cls          = CLS_ERR;
            err_cnt_next = btc_bump(err_base);
        end
        else if (btc_flag(compare_mode_reg, con_ext, s2_warn_lim_reg))
        begin
            cls           = CLS_WARN;
            warn_cnt_next = btc_bump(warn_base);
        end
        else
        begin
            cls           = CLS_GOOD;
            good_cnt_next = btc_bump(good_base);
        end
    end

    assign cnt_sum = SUM_W'(err_cnt_next) + SUM_W'(warn_cnt_next) + SUM_W'(good_cnt_next);
    assign lim_ext = {{(SUM_W + 1 - PLIM_W){publish_limit_reg[PLIM_W-1]}}, publish_limit_reg};
    assign under_limit = ($signed({1'b0, cnt_sum}) <= lim_ext);

    // Decide whether this bin is listed
    always_comb
    begin
        pub = 1'b0;
        if (under_limit)
        begin
            unique case (cls)
                CLS_ERR:  pub = 1'b1;
                CLS_WARN: pub = (publish_type_reg >= PUB_WARN);
                CLS_GOOD: pub = (publish_type_reg >= PUB_ALL);
                default:  pub = 1'b0;
            endcase
        end
    end

    // Worst-case status on the last bin
    always_comb
    begin
        priority if (!s2_last_reg)
            st = ST_GREEN;
        else if (err_cnt_next != '0)
            st = ST_RED;
        else if (warn_cnt_next != '0)
            st = ST_YELLOW;
        else
            st = ST_GREEN;
    end

    // Hold counters; update as each check leaves stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_cnt_reg  <= '0;
            warn_cnt_reg <= '0;
            good_cnt_reg <= '0;
        end
        else if (s2_move)
        begin
            err_cnt_reg  <= err_cnt_next;
            warn_cnt_reg <= warn_cnt_next;
            good_cnt_reg <= good_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic             out_valid_next;
    logic [1:0]       bin_class_reg;
    logic             publish_reg;
    logic [CNT_W-1:0] error_count_reg;
    logic [CNT_W-1:0] warning_count_reg;
    logic [1:0]       status_reg;
    logic             done_res_reg;

    always_comb
    begin
        if (s2_move)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            bin_class_reg     <= cls;
            publish_reg       <= pub;
            error_count_reg   <= err_cnt_next;
            warning_count_reg <= warn_cnt_next;
            status_reg        <= st;
            done_res_reg      <= s2_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bin_class     = bin_class_reg;
    assign publish       = publish_reg;
    assign error_count   = error_count_reg;
    assign warning_count = warning_count_reg;
    assign status        = status_reg;
    assign done_res      = done_res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_check_enters_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == OP_CHECK) |=> s1_valid_reg
    ) else $error("accepted check word did not enter stage 1");

    a_skip_not_listed: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && bin_class == CLS_SKIP) |-> !publish
    ) else $error("skipped bin flagged for publishing");

    a_red_has_errors: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && done_res && status == ST_RED) |-> (error_count != '0)
    ) else $error("red status without any error counted");

    a_status_only_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (status == ST_GREEN)
    ) else $error("status given on a bin other than the last");

endmodule

`default_nettype wire

// ===== rtl/btc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module btc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; hold data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
